// ===== rtl/plt_pkg.sv =====
// ---------------------------------------------------------------------------
// plt_pkg: shared types and constants for the positional list table
// Item layouts, operation and status codes, and the per-cell control word.
// ---------------------------------------------------------------------------
package plt_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = 7;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        [1:0]             operation;
    logic        [CNT_W-1:0]       slot;
    logic signed [VALUE_WIDTH-1:0] value_in;
  } plt_in_t;

  typedef struct packed {
    logic        [1:0]             status;
    logic signed [VALUE_WIDTH-1:0] value_out;
    logic        [CNT_W-1:0]       found_slot;
    logic        [CNT_W-1:0]       count_out;
  } plt_out_t;

  // control word broadcast to every cell of the row
  typedef struct packed {
    logic                   load;    // capture compare and read results
    logic                   ins;     // open a gap at pos and write value
    logic                   del;     // close the gap at pos
    logic                   get;     // present the entry at pos
    logic                   find;    // compare entries against value
    logic [CNT_W-1:0]       pos;     // zero-based position
    logic [CNT_W-1:0]       count;   // entries held before the operation
    logic [VALUE_WIDTH-1:0] value;
  } plt_cell_ctl_t;

endpackage

// ===== rtl/positional_list_table_top.sv =====
// ---------------------------------------------------------------------------
// positional_list_table_top: ordered list with insert, delete, get and find
// A row of cells holds the list; insert and delete shift the whole row in parallel.
//
//   channel | direction | payload   | handshake
//   in      | input     | plt_in_t  | in_valid / in_stall
//   out     | output    | plt_out_t | out_valid / out_stall
//
// Each item passes through accept, cell update and result collect in turn.
// One item is in flight at a time; a new item is taken while the previous
// result still waits in the output register.
// Reset clears the entry count and handshake state; entries are not cleared.
// A stalled output holds the collect step until the register frees up.
// ---------------------------------------------------------------------------
module positional_list_table_top
  import plt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  plt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output plt_out_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CELL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [CNT_W-1:0]       count;
  logic [1:0]             op;
  logic [CNT_W-1:0]       slot;
  logic [VALUE_WIDTH-1:0] value;
  logic [1:0]             status;

  logic                   accept;
  logic                   pos_ok;
  logic [1:0]             status_next;
  logic                   do_ins;
  logic                   do_del;
  plt_cell_ctl_t          ctl;

  logic [VALUE_WIDTH-1:0] entries [CAPACITY];
  logic [VALUE_WIDTH-1:0] rds [CAPACITY];
  logic [CAPACITY-1:0]    hits;
  logic                   any_hit;
  logic [CNT_W-1:0]       first_slot;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   out_free;
  plt_out_t               result;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // check the position against the count held before the operation
  always_comb begin
    if (op == OP_INSERT) begin
      pos_ok = (slot != '0) && ({1'b0, slot} <= ({1'b0, count} + (CNT_W + 1)'(1)));
    end else begin
      pos_ok = (slot != '0) && (slot <= count);
    end
  end

  always_comb begin
    status_next = ST_OK;
    case (op)
      OP_INSERT: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else if (count >= CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end
      end
      OP_DELETE, OP_GET: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  assign do_ins = (state == S_CELL) && (op == OP_INSERT) && (status_next == ST_OK);
  assign do_del = (state == S_CELL) && (op == OP_DELETE) && (status_next == ST_OK);

  // drive the row
  always_comb begin
    ctl.load  = (state == S_CELL);
    ctl.ins   = do_ins;
    ctl.del   = do_del;
    ctl.get   = (op == OP_GET) && (status_next == ST_OK);
    ctl.find  = (op == OP_FIND);
    ctl.pos   = slot - CNT_W'(1);
    ctl.count = count;
    ctl.value = value;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entries[g+1];
    end
    plt_cell u_cell (
      .clk   (clk),
      .idx   (CNT_W'(g)),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .entry (entries[g]),
      .hit   (hits[g]),
      .rd    (rds[g])
    );
  end

  plt_scan u_scan (
    .hits       (hits),
    .rds        (rds),
    .any_hit    (any_hit),
    .first_slot (first_slot),
    .rd_value   (rd_value)
  );

  // assemble the result item
  always_comb begin
    result.count_out  = count;
    result.value_out  = rd_value;
    result.found_slot = '0;
    result.status     = status;
    if (op == OP_FIND) begin
      if (any_hit) begin
        result.status     = ST_OK;
        result.found_slot = first_slot;
      end else begin
        result.status = ST_NOTFOUND;
      end
    end
  end

  // sequence one item
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CELL;
        end
      end
      S_CELL: state_next = S_SCAN;
      S_SCAN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advance the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + CNT_W'(1);
    end else if (do_del) begin
      count <= count - CNT_W'(1);
    end
  end

  // hold the item fields and the checked status
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= in_data.operation;
      slot  <= in_data.slot;
      value <= in_data.value_in;
    end
    if (state == S_CELL) begin
      status <= status_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_SCAN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && out_free) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/plt_cell.sv =====
// ---------------------------------------------------------------------------
// plt_cell: one list entry
// Holds one value, takes it from a neighbor on insert or delete (or the new value at pos), and flags
// a compare hit or presents its value for a read.
// ---------------------------------------------------------------------------
module plt_cell
  import plt_pkg::*;
(
  input  logic                   clk,
  input  logic [CNT_W-1:0]       idx,
  input  plt_cell_ctl_t          ctl,
  input  logic [VALUE_WIDTH-1:0] left,
  input  logic [VALUE_WIDTH-1:0] right,
  output logic [VALUE_WIDTH-1:0] entry,
  output logic                   hit,
  output logic [VALUE_WIDTH-1:0] rd
);

  // shift the row: insert pulls from the lower neighbor, delete from the upper
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        entry <= ctl.value;
      end else if (idx > ctl.pos) begin
        entry <= left;
      end
    end else if (ctl.del) begin
      if (idx >= ctl.pos) begin
        entry <= right;
      end
    end
  end

  // capture compare hit and masked read value
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit <= ctl.find && (idx < ctl.count) && (entry == ctl.value);
      rd  <= (ctl.get && idx == ctl.pos) ? entry : '0;
    end
  end

endmodule

// ===== rtl/plt_scan.sv =====
// ---------------------------------------------------------------------------
// plt_scan: row result collector
// Finds the lowest cell with a compare hit and merges the read values.
// ---------------------------------------------------------------------------
module plt_scan
  import plt_pkg::*;
(
  input  logic [CAPACITY-1:0]    hits,
  input  logic [VALUE_WIDTH-1:0] rds [CAPACITY],
  output logic                   any_hit,
  output logic [CNT_W-1:0]       first_slot,
  output logic [VALUE_WIDTH-1:0] rd_value
);

  // priority encode from the top down so the lowest hit wins
  always_comb begin
    first_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first_slot = CNT_W'(i + 1);
      end
    end
  end

  assign any_hit = |hits;

  // only the addressed cell presents a nonzero read value
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | rds[i];
    end
  end

endmodule

// ===== tb/tb_positional_list_table_top.sv =====
// ---------------------------------------------------------------------------
// tb_positional_list_table_top: self-checking bench for the positional list
// Drives insert, delete, get and find requests and mirrors the list in a
// shadow copy. Every reply is checked field by field against that copy.
// ---------------------------------------------------------------------------
module tb_positional_list_table_top
  import plt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 850;
  localparam int CALM_ITEMS     = 80;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;

  localparam logic signed [VALUE_WIDTH-1:0] MAXV = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] MINV = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} traffic_mode_t;

  // Shadow copy of the list plus the queue of replies it predicts
  class list_table_board;
    logic signed [VALUE_WIDTH-1:0] shadow_list [CAPACITY];
    int                            shadow_count;
    plt_out_t                      pending_replies [$];
    int                            mismatches;
    int                            reply_index;

    function new();
      shadow_count = 0;
      mismatches   = 0;
      reply_index  = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its reply
    function void apply_request(plt_in_t req);
      plt_out_t reply;
      int       pos;
      int       i;
      reply = '0;
      reply.status = ST_OK;
      pos = int'(req.slot);
      case (req.operation)
        OP_INSERT: begin
          if (pos < 1 || pos > shadow_count + 1) begin
            reply.status = ST_RANGE;
          end else if (shadow_count >= CAPACITY) begin
            reply.status = ST_FULL;
          end else begin
            for (i = shadow_count; i > pos - 1; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[pos-1] = req.value_in;
            shadow_count++;
          end
        end
        OP_DELETE: begin
          if (pos < 1 || pos > shadow_count) begin
            reply.status = ST_RANGE;
          end else begin
            for (i = pos - 1; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
          end
        end
        OP_GET: begin
          if (pos < 1 || pos > shadow_count) reply.status = ST_RANGE;
          else reply.value_out = shadow_list[pos-1];
        end
        default: begin
          // lowest matching position wins
          reply.status = ST_NOTFOUND;
          for (i = 0; i < shadow_count; i++) begin
            if (shadow_list[i] == req.value_in) begin
              reply.found_slot = CNT_W'(i + 1);
              reply.status     = ST_OK;
              break;
            end
          end
        end
      endcase
      reply.count_out = CNT_W'(shadow_count);
      pending_replies.push_back(reply);
    endfunction

    task report(string msg);
      $display("[%0t] reply %0d: %s", $realtime, reply_index, msg);
      mismatches++;
    endtask

    // Compare one reply with the oldest prediction
    task check_response(plt_out_t got);
      plt_out_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply with no request outstanding: %h", got));
        reply_index++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.value_out !== want.value_out)
        report($sformatf("value_out got %0d want %0d", got.value_out, want.value_out));
      if (got.found_slot !== want.found_slot)
        report($sformatf("found_slot got %0d want %0d", got.found_slot, want.found_slot));
      if (got.count_out !== want.count_out)
        report($sformatf("count_out got %0d want %0d", got.count_out, want.count_out));
      reply_index++;
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  plt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  plt_out_t out_data;

  list_table_board sb = new();
  int              items_sent = 0;
  bit              calm = 1'b0;
  bit              held_long = 1'b0;
  int              idle_cycles = 0;

  positional_list_table_top uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic plt_in_t mk(logic [1:0] op, int slot, logic signed [VALUE_WIDTH-1:0] v);
    plt_in_t req;
    req.operation = op;
    req.slot      = CNT_W'(slot);
    req.value_in  = v;
    return req;
  endfunction

  // Favor values already held so finds hit, plus extremes and a small pool
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value(bit for_find);
    int r;
    r = $urandom_range(0, 9);
    if (for_find && sb.shadow_count > 0 && r < 6)
      return sb.shadow_list[$urandom_range(0, sb.shadow_count - 1)];
    if (r < 4) begin
      case ($urandom_range(0, 4))
        0:       return MINV;
        1:       return MAXV;
        2:       return -1;
        3:       return 0;
        default: return VALUE_WIDTH'($urandom_range(0, 7));
      endcase
    end
    return VALUE_WIDTH'($urandom);
  endfunction

  // Build one request: mostly well-placed, with some noise on any field
  function automatic plt_in_t make_request(traffic_mode_t mode);
    plt_in_t req;
    int      n;
    int      r;
    n = sb.shadow_count;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      req.operation = 2'($urandom_range(0, 3));
      req.slot      = CNT_W'($urandom_range(0, 127));
      req.value_in  = VALUE_WIDTH'($urandom);
      return req;
    end
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   req.operation = r < 75 ? OP_INSERT : r < 80 ? OP_DELETE :
                                   r < 90 ? OP_GET : OP_FIND;
      MODE_SHRINK: req.operation = r < 25 ? OP_INSERT : r < 75 ? OP_DELETE :
                                   r < 88 ? OP_GET : OP_FIND;
      default:     req.operation = r < 40 ? OP_INSERT : r < 65 ? OP_DELETE :
                                   r < 82 ? OP_GET : OP_FIND;
    endcase
    case (req.operation)
      OP_INSERT: begin
        // on a full list, sometimes aim past the end as well
        if (n == CAPACITY && $urandom_range(0, 4) == 0)
          req.slot = CNT_W'($urandom_range(n + 2, 127));
        else
          req.slot = CNT_W'($urandom_range(1, n + 1));
      end
      OP_FIND: req.slot = CNT_W'($urandom_range(0, 127));
      default: req.slot = CNT_W'(n > 0 ? $urandom_range(1, n) : 1);
    endcase
    req.value_in = pick_value(req.operation == OP_FIND);
    return req;
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_request(plt_in_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_request(req);
    items_sent++;
  endtask

  task automatic idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted reply is back
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, one long hold, free stretches between
  initial begin
    out_stall = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    while (!calm) begin
      if (!held_long && items_sent >= 300) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        held_long = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Check replies and watch for a stuck handshake
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_response(out_data);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    traffic_mode_t mode;
    int            phase_left;
    int            gap_rate;
    int            k;
    bit            drained_mid;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    drained_mid = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty list: every position is out of range, find misses
    send_request(mk(OP_GET,    1, 0));
    send_request(mk(OP_DELETE, 1, 0));
    send_request(mk(OP_FIND,   0, 0));
    send_request(mk(OP_INSERT, 0, 5));
    send_request(mk(OP_INSERT, 2, 5));
    // build a list with extremes and a repeated value
    send_request(mk(OP_INSERT, 1, MAXV));
    send_request(mk(OP_INSERT, 2, MINV));
    send_request(mk(OP_INSERT, 1, -1));
    send_request(mk(OP_INSERT, 3, 0));
    send_request(mk(OP_INSERT, 5, MINV));
    // find reports the first match and ignores the position field
    send_request(mk(OP_FIND, 127, MINV));
    send_request(mk(OP_FIND, 0, MINV + 1));
    send_request(mk(OP_FIND, 5, MAXV - 1));
    // position zero, positions past the end and in-range accesses
    send_request(mk(OP_GET,    0, 0));
    send_request(mk(OP_GET,    5, 0));
    send_request(mk(OP_GET,    6, 0));
    send_request(mk(OP_GET,    127, 0));
    send_request(mk(OP_DELETE, 0, 0));
    send_request(mk(OP_DELETE, 127, 0));
    send_request(mk(OP_DELETE, 5, 0));
    send_request(mk(OP_DELETE, 1, 0));
    send_request(mk(OP_INSERT, 127, -1));
    send_request(mk(OP_INSERT, 4, 32'sh5555_5555));
    send_request(mk(OP_FIND,   0, 0));
    send_request(mk(OP_GET,    1, -1));
    drain_replies();

    // random phases; the first one grows the list toward capacity
    mode       = MODE_GROW;
    phase_left = 150;
    gap_rate   = 2;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (phase_left == 0) begin
        mode       = traffic_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(40, 150);
        gap_rate   = $urandom_range(0, 4);
      end
      phase_left--;
      if (k >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!drained_mid && k == RANDOM_ITEMS / 2) begin
        drain_replies();
        drained_mid = 1'b1;
      end
      if (!calm && gap_rate > 0 && $urandom_range(0, 9) < gap_rate)
        idle_sender($urandom_range(1, 16));
      send_request(make_request(mode));
    end

    // wait out the last replies, then let the pipeline settle
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
